>>> sv/scp_pkg.sv
// Shared constants, codes and control structs of the serial command line parser.
package scp_pkg;

  localparam int unsigned LineCapacity = 32;
  localparam int unsigned StoreDepth   = LineCapacity - 1;
  localparam int unsigned AddrW        = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned LenW         = $clog2(LineCapacity);
  localparam int unsigned AccW         = 9;
  localparam int unsigned ByteW        = 8;

  localparam logic [AccW-1:0] AccSat = 9'd256;

  localparam logic [ByteW-1:0] ChrLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChrCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChrSpace = 8'h20;
  localparam logic [ByteW-1:0] ChrTab   = 8'h09;
  localparam logic [ByteW-1:0] ChrVt    = 8'h0B;
  localparam logic [ByteW-1:0] ChrFf    = 8'h0C;
  localparam logic [ByteW-1:0] ChrLowS  = 8'h73;
  localparam logic [ByteW-1:0] ChrUpS   = 8'h53;
  localparam logic [ByteW-1:0] ChrPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChrMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChrZero  = 8'h30;
  localparam logic [ByteW-1:0] ChrNine  = 8'h39;
  localparam logic [ByteW-1:0] ChrNul   = 8'h00;

  localparam logic [ByteW-1:0] ChannelLimitReset = 8'd8;

  localparam logic [2:0] PhFirst  = 3'd0;
  localparam logic [2:0] PhLeadWs = 3'd1;
  localparam logic [2:0] PhSign   = 3'd2;
  localparam logic [2:0] PhDigits = 3'd3;
  localparam logic [2:0] PhValue  = 3'd4;
  localparam logic [2:0] PhStop   = 3'd5;
  localparam logic [2:0] PhReject = 3'd6;

  localparam logic ResHeader = 1'b0;
  localparam logic ResText   = 1'b1;

  localparam logic [1:0] KindNone    = 2'd0;
  localparam logic [1:0] KindStopAll = 2'd1;
  localparam logic [1:0] KindChannel = 2'd2;

  typedef struct packed {
    logic store_byte;
    logic load_hdr;
    logic load_txt;
    logic rd_start;
    logic rd_next;
    logic clear_line;
  } scp_cmd_t;

  typedef struct packed {
    logic rx_eol;
    logic line_empty;
    logic hdr_text;
    logic txt_last;
  } scp_sts_t;

endpackage

>>> sv/serial_command_line_parser_top.sv
// Top level of the serial command line parser: controller, datapath and ports.
//
// Channel   Direction  Handshake             Payload
// in        in         in_valid_i/in_stall_o  rx_byte_i
// out       out        out_valid_o/out_stall_i result_type_o, command_kind_o,
//                                             channel_number_o, text_byte_o, last_of_run_o
// cfg       in         cfg_valid_i/cfg_ready_o channel_limit_i
//
// A byte not CR or LF is taken in idle and, given room, stored and parsed at once.
// A non-empty line end emits a header beat, then each value text beat passes a read
// state first because the single read port of the line store has registered read data.
// A line end with the most value bytes, twenty-nine, thus stalls the input until
// its last text beat is loaded, plus any time of output stall.
// Reset clears the line and sets channel_limit to 8; the store holds no reset value.
// A stall on the output holds the result register; input is stalled while a run is out.
module serial_command_line_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_type_o,
  output logic [1:0]  command_kind_o,
  output logic [7:0]  channel_number_o,
  output logic [7:0]  text_byte_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  channel_limit_i
);
  import scp_pkg::*;

  scp_cmd_t cmd;
  scp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  scp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_byte_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .channel_limit_i  (channel_limit_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_type_o    (result_type_o),
    .command_kind_o   (command_kind_o),
    .channel_number_o (channel_number_o),
    .text_byte_o      (text_byte_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

>>> sv/scp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 31,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/scp_dp.sv
// Datapath: line store, incremental parser, channel limit and result register.
module scp_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [scp_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                        cfg_we_i,
  input  logic [scp_pkg::ByteW-1:0]   channel_limit_i,
  input  scp_pkg::scp_cmd_t           cmd_i,
  output scp_pkg::scp_sts_t           sts_o,
  output logic                        result_type_o,
  output logic [1:0]                  command_kind_o,
  output logic [scp_pkg::ByteW-1:0]   channel_number_o,
  output logic [scp_pkg::ByteW-1:0]   text_byte_o,
  output logic                        last_of_run_o
);
  import scp_pkg::*;

  function automatic logic is_blank(input logic [ByteW-1:0] b);
    return (b == ChrSpace) || (b == ChrTab) || (b == ChrVt) || (b == ChrFf);
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] b);
    return (b >= ChrZero) && (b <= ChrNine);
  endfunction

  logic [LenW-1:0]  len_q, len_d;
  logic [2:0]       phase_q, phase_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [LenW-1:0]  vstart_q, vstart_d;
  logic [LenW-1:0]  vend_q, vend_d;
  logic             zseen_q, zseen_d;
  logic [LenW-1:0]  rd_addr_q, rd_addr_d;
  logic [ByteW-1:0] limit_q;

  logic             res_type_q;
  logic [1:0]       res_kind_q;
  logic [ByteW-1:0] res_chan_q;
  logic [ByteW-1:0] res_text_q;
  logic             res_last_q;

  logic             room;
  logic             do_store;
  logic [LenW-1:0]  len_inc;
  logic [11:0]      acc_ext;
  logic [11:0]      acc_sum;
  logic [AccW-1:0]  acc_next;
  logic             is_chan_cmd;
  logic [1:0]       hdr_kind;
  logic             hdr_last;
  logic [ByteW-1:0] ram_rdata;

  assign room     = (len_q < LenW'(StoreDepth));
  assign do_store = cmd_i.store_byte && room;
  assign len_inc  = len_q + LenW'(1);

  assign acc_ext  = {3'b000, acc_q};
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {8'h00, rx_byte_i[3:0]};
  assign acc_next = (acc_sum > {3'b000, AccSat}) ? AccSat : acc_sum[AccW-1:0];

  always_comb begin
    len_d    = len_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    vstart_d = vstart_q;
    vend_d   = vend_q;
    zseen_d  = zseen_q;
    if (cmd_i.clear_line) begin
      len_d    = '0;
      phase_d  = PhFirst;
      acc_d    = '0;
      neg_d    = 1'b0;
      vstart_d = '0;
      vend_d   = '0;
      zseen_d  = 1'b0;
    end else if (do_store) begin
      len_d = len_inc;
      if (rx_byte_i == ChrNul && phase_q != PhValue && phase_q != PhStop) begin
        phase_d = PhReject;
      end else begin
        unique case (phase_q)
          PhFirst: begin
            if (rx_byte_i == ChrLowS || rx_byte_i == ChrUpS) begin
              phase_d = PhStop;
            end else if (is_blank(rx_byte_i)) begin
              phase_d = PhLeadWs;
            end else if (rx_byte_i == ChrPlus || rx_byte_i == ChrMinus) begin
              neg_d   = (rx_byte_i == ChrMinus);
              phase_d = PhSign;
            end else if (is_digit(rx_byte_i)) begin
              acc_d   = acc_next;
              phase_d = PhDigits;
            end else begin
              phase_d = PhReject;
            end
          end
          PhLeadWs: begin
            if (is_blank(rx_byte_i)) begin
              phase_d = PhLeadWs;
            end else if (rx_byte_i == ChrPlus || rx_byte_i == ChrMinus) begin
              neg_d   = (rx_byte_i == ChrMinus);
              phase_d = PhSign;
            end else if (is_digit(rx_byte_i)) begin
              acc_d   = acc_next;
              phase_d = PhDigits;
            end else begin
              phase_d = PhReject;
            end
          end
          PhSign: begin
            if (is_digit(rx_byte_i)) begin
              acc_d   = acc_next;
              phase_d = PhDigits;
            end else begin
              phase_d = PhReject;
            end
          end
          PhDigits: begin
            if (is_digit(rx_byte_i)) begin
              acc_d = acc_next;
            end else if (rx_byte_i == ChrSpace) begin
              vstart_d = len_inc;
              vend_d   = len_inc;
              phase_d  = PhValue;
            end else begin
              phase_d = PhReject;
            end
          end
          PhValue: begin
            // The value text ends at the first zero byte after the separator.
            if (!zseen_q) begin
              if (rx_byte_i == ChrNul) begin
                zseen_d = 1'b1;
              end else begin
                vend_d = len_inc;
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_comb begin
    rd_addr_d = rd_addr_q;
    if (cmd_i.rd_start) begin
      rd_addr_d = vstart_q;
    end else if (cmd_i.rd_next) begin
      rd_addr_d = rd_addr_q + LenW'(1);
    end
  end

  assign is_chan_cmd = (phase_q == PhValue) && !(neg_q && (acc_q != '0)) &&
                       (acc_q < {1'b0, limit_q});

  always_comb begin
    if (phase_q == PhStop) begin
      hdr_kind = KindStopAll;
      hdr_last = 1'b1;
    end else if (is_chan_cmd) begin
      hdr_kind = KindChannel;
      hdr_last = (vend_q == vstart_q);
    end else begin
      hdr_kind = KindNone;
      hdr_last = 1'b1;
    end
  end

  assign sts_o.rx_eol     = (rx_byte_i == ChrLf) || (rx_byte_i == ChrCr);
  assign sts_o.line_empty = (len_q == '0);
  assign sts_o.hdr_text   = is_chan_cmd && (vend_q != vstart_q);
  assign sts_o.txt_last   = ((rd_addr_q + LenW'(1)) == vend_q);

  scp_ram #(
    .Width (ByteW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_store),
    .waddr_i (len_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (rd_addr_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      phase_q   <= PhFirst;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      vstart_q  <= '0;
      vend_q    <= '0;
      zseen_q   <= 1'b0;
      rd_addr_q <= '0;
      limit_q   <= ChannelLimitReset;
    end else begin
      len_q     <= len_d;
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      vstart_q  <= vstart_d;
      vend_q    <= vend_d;
      zseen_q   <= zseen_d;
      rd_addr_q <= rd_addr_d;
      if (cfg_we_i) begin
        limit_q <= channel_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hdr) begin
      res_type_q <= ResHeader;
      res_kind_q <= hdr_kind;
      res_chan_q <= (hdr_kind == KindChannel) ? acc_q[ByteW-1:0] : '0;
      res_text_q <= '0;
      res_last_q <= hdr_last;
    end else if (cmd_i.load_txt) begin
      res_type_q <= ResText;
      res_kind_q <= KindNone;
      res_chan_q <= '0;
      res_text_q <= ram_rdata;
      res_last_q <= sts_o.txt_last;
    end
  end

  assign result_type_o    = res_type_q;
  assign command_kind_o   = res_kind_q;
  assign channel_number_o = res_chan_q;
  assign text_byte_o      = res_text_q;
  assign last_of_run_o    = res_last_q;

  a_value_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vstart_q <= vend_q) && (vend_q <= len_q))
    else $error("value window lies outside the stored line");

  a_txt_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_txt |-> (rd_addr_q >= vstart_q) && (rd_addr_q < vend_q))
    else $error("text beat read outside the value window");

  a_hdr_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_hdr |-> (len_q != '0))
    else $error("header emitted for an empty line");

  a_clear_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_line |=> (len_q == '0) && (phase_q == PhFirst))
    else $error("line state not cleared after its last beat");

endmodule

>>> sv/scp_ctrl.sv
// Controller: accepts input beats and sequences header and text result beats.
module scp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  scp_pkg::scp_sts_t sts_i,
  output scp_pkg::scp_cmd_t cmd_o
);
  import scp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StHdr  = 2'd1;
  localparam logic [1:0] StRd   = 2'd2;
  localparam logic [1:0] StTxt  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.rx_eol) begin
            if (!sts_i.line_empty) begin
              state_d = StHdr;
            end
          end else begin
            cmd_o.store_byte = 1'b1;
          end
        end
      end
      StHdr: begin
        if (slot_free) begin
          cmd_o.load_hdr = 1'b1;
          out_valid_d    = 1'b1;
          if (sts_i.hdr_text) begin
            cmd_o.rd_start = 1'b1;
            state_d        = StRd;
          end else begin
            cmd_o.clear_line = 1'b1;
            state_d          = StIdle;
          end
        end
      end
      StRd: begin
        state_d = StTxt;
      end
      StTxt: begin
        if (slot_free) begin
          cmd_o.load_txt = 1'b1;
          out_valid_d    = 1'b1;
          if (sts_i.txt_last) begin
            cmd_o.clear_line = 1'b1;
            state_d          = StIdle;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = StRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_hdr || cmd_o.load_txt) |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while its beat is stalled");

  a_rd_feeds_txt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_start || cmd_o.rd_next) |=> (state_q == StRd) ##1 (state_q == StTxt))
    else $error("store read not followed by a text beat");

  a_eol_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.rx_eol && !sts_i.line_empty) |=> (state_q == StHdr))
    else $error("line end did not start a header beat");

endmodule

>>> dv/scp_line_sb_pkg.sv
// Line parser prediction and result beat checking for the serial command line parser bench.
package scp_line_sb_pkg;
  import scp_pkg::*;

  typedef struct packed {
    logic       rtype;
    logic [1:0] kind;
    logic [7:0] chan;
    logic [7:0] text;
    logic       last;
  } line_beat_t;

  class line_scoreboard;
    logic [ByteW-1:0] store [StoreDepth];
    int unsigned      len;
    logic [2:0]       phase;
    int unsigned      accum;
    bit               neg;
    int unsigned      vstart;
    logic [7:0]       channel_limit;
    line_beat_t       line_beats_q[$];
    int               errors;
    int               beats_checked;
    int               lines_ended;

    function new();
      channel_limit = ChannelLimitReset;
      errors        = 0;
      beats_checked = 0;
      lines_ended   = 0;
      clear_line();
    endfunction

    function void clear_line();
      len    = 0;
      phase  = PhFirst;
      accum  = 0;
      neg    = 1'b0;
      vstart = 0;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == ChrSpace || b == ChrTab || b == ChrVt || b == ChrFf;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= ChrZero && b <= ChrNine;
    endfunction

    function void add_digit(logic [7:0] b);
      int unsigned v;
      v = accum * 10 + (int'(b) - int'(ChrZero));
      accum = (v > AccSat) ? AccSat : v;
    endfunction

    function void start_number(logic [7:0] b);
      if (b == ChrPlus || b == ChrMinus) begin
        neg   = (b == ChrMinus);
        phase = PhSign;
      end else if (is_digit(b)) begin
        add_digit(b);
        phase = PhDigits;
      end else begin
        phase = PhReject;
      end
    endfunction

    function void parse_char(logic [7:0] b, int unsigned pos);
      case (phase)
        PhFirst: begin
          if (b == ChrLowS || b == ChrUpS) phase = PhStop;
          else if (is_blank(b)) phase = PhLeadWs;
          else start_number(b);
        end
        PhLeadWs: begin
          if (!is_blank(b)) start_number(b);
        end
        PhSign: begin
          if (is_digit(b)) begin
            add_digit(b);
            phase = PhDigits;
          end else begin
            phase = PhReject;
          end
        end
        PhDigits: begin
          if (is_digit(b)) begin
            add_digit(b);
          end else if (b == ChrSpace) begin
            vstart = pos + 1;
            phase  = PhValue;
          end else begin
            phase = PhReject;
          end
        end
        default: ;
      endcase
    endfunction

    function void push(logic rtype, logic [1:0] kind, logic [7:0] chan, logic [7:0] text,
                       logic last);
      line_beats_q.push_back('{rtype, kind, chan, text, last});
    endfunction

    function void take_rx_byte(logic [7:0] b);
      int unsigned stop_at;
      if (b != ChrLf && b != ChrCr) begin
        if (len + 1 < LineCapacity) begin
          store[len] = b;
          if (b == ChrNul && phase != PhValue && phase != PhStop) phase = PhReject;
          else parse_char(b, len);
          len++;
        end
        return;
      end
      if (len == 0) return;
      lines_ended++;
      if (phase == PhStop) begin
        push(ResHeader, KindStopAll, 8'd0, 8'd0, 1'b1);
      end else if (phase == PhValue && !(neg && accum != 0) && accum < channel_limit) begin
        stop_at = vstart;
        while (stop_at < len && stop_at < StoreDepth && store[stop_at] != ChrNul) stop_at++;
        push(ResHeader, KindChannel, accum[7:0], 8'd0, stop_at == vstart);
        for (int unsigned i = vstart; i < stop_at; i++) begin
          push(ResText, KindNone, 8'd0, store[i], i + 1 == stop_at);
        end
      end else begin
        push(ResHeader, KindNone, 8'd0, 8'd0, 1'b1);
      end
      clear_line();
    endfunction

    function int pending();
      return line_beats_q.size();
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(line_beat_t got);
      line_beat_t want;
      if (line_beats_q.size() == 0) begin
        report($sformatf("unexpected beat type=%0d kind=%0d chan=%0d text=%02h last=%0d",
                         got.rtype, got.kind, got.chan, got.text, got.last));
        return;
      end
      want = line_beats_q.pop_front();
      beats_checked++;
      if (got.rtype !== want.rtype)
        report($sformatf("beat %0d result_type %0d, expected %0d",
                         beats_checked, got.rtype, want.rtype));
      if (got.kind !== want.kind)
        report($sformatf("beat %0d command_kind %0d, expected %0d",
                         beats_checked, got.kind, want.kind));
      if (got.chan !== want.chan)
        report($sformatf("beat %0d channel_number %0d, expected %0d",
                         beats_checked, got.chan, want.chan));
      if (got.text !== want.text)
        report($sformatf("beat %0d text_byte %02h, expected %02h",
                         beats_checked, got.text, want.text));
      if (got.last !== want.last)
        report($sformatf("beat %0d last_of_run %0d, expected %0d",
                         beats_checked, got.last, want.last));
    endtask
  endclass

endpackage

>>> dv/tb_serial_command_line_parser_top.sv
// Self-checking testbench of the serial command line parser top level.
module tb_serial_command_line_parser_top;
  import scp_pkg::*;
  import scp_line_sb_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 80;
  localparam int PhaseBytes  = 76;

  localparam logic [7:0] Directed [24] = '{
    ChrUpS, ChrLf,
    ChrCr,
    ChrMinus, ChrZero, ChrSpace, ChrLf,
    "7", ChrSpace, 8'hFF, ChrNul, "b", ChrCr,
    ChrPlus, "9", "9", "9", ChrSpace, ChrLf,
    ChrTab, "1", ChrNul, ChrSpace, ChrLf
  };

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i       = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic       result_type_o;
  logic [1:0] command_kind_o;
  logic [7:0] channel_number_o;
  logic [7:0] text_byte_o;
  logic       last_of_run_o;
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] channel_limit_i = 8'd0;

  logic [7:0]     blanks [4]      = '{ChrSpace, ChrTab, ChrVt, ChrFf};
  logic [7:0]     phase_limit [5] = '{8'd255, 8'd0, 8'd1, 8'd8, 8'd8};
  int             phase_send [5]  = '{0, 81, 0, 34, 0};
  int             phase_stall [5] = '{0, 0, 81, 34, 0};
  logic [7:0]     line_q[$];
  int             send_idle_pct   = 0;
  int             stall_pct       = 0;
  int             cycles          = 0;
  int             bytes_sent;
  line_beat_t     seen;
  line_scoreboard sb;

  serial_command_line_parser_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_type_o    (result_type_o),
    .command_kind_o   (command_kind_o),
    .channel_number_o (channel_number_o),
    .text_byte_o      (text_byte_o),
    .last_of_run_o    (last_of_run_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .channel_limit_i  (channel_limit_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("serial_command_line_parser_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  // A result beat is taken at the next rising edge when valid is high and stall is low.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{result_type_o, command_kind_o, channel_number_o, text_byte_o, last_of_run_o};
      sb.check_result(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    bit taken;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) sb.take_rx_byte(b);
      @(posedge clk_i);
    end
  endtask

  task automatic write_limit(input logic [7:0] v);
    bit taken;
    cfg_valid_i     <= 1'b1;
    channel_limit_i <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    sb.channel_limit = v;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic make_line();
    int    form;
    int    n;
    int    nval;
    string digits;
    line_q.delete();
    form = $urandom_range(99, 0);
    if (form < 10) begin
      line_q.push_back($urandom_range(1, 0) ? ChrLowS : ChrUpS);
      repeat ($urandom_range(4, 0)) line_q.push_back(8'($urandom_range(255, 0)));
    end else if (form < 85) begin
      repeat ($urandom_range(2, 0)) line_q.push_back(blanks[$urandom_range(3, 0)]);
      case ($urandom_range(3, 0))
        0: line_q.push_back(ChrPlus);
        1: line_q.push_back(ChrMinus);
        default: ;
      endcase
      n = ($urandom_range(9, 0) < 7) ? $urandom_range(sb.channel_limit + 2, 0)
                                     : $urandom_range(9999, 0);
      if ($urandom_range(7, 0) == 0) line_q.push_back(ChrZero);
      digits = $sformatf("%0d", n);
      foreach (digits[i]) line_q.push_back(digits[i]);
      line_q.push_back(ChrSpace);
      nval = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 0);
      repeat (nval) begin
        case ($urandom_range(9, 0))
          0: line_q.push_back(ChrNul);
          1: line_q.push_back(8'($urandom_range(255, 0)));
          default: line_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
        endcase
      end
      if (form >= 75) line_q[$urandom_range(line_q.size() - 1, 0)] = 8'($urandom_range(255, 0));
    end else begin
      repeat ($urandom_range(8, 0)) line_q.push_back(8'($urandom_range(255, 0)));
    end
    line_q.push_back($urandom_range(1, 0) ? ChrLf : ChrCr);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i]) send_byte(Directed[i]);
    drain();

    for (int p = 0; p < 5; p++) begin
      send_idle_pct = phase_send[p];
      stall_pct     = phase_stall[p];
      write_limit((p == 3) ? 8'($urandom_range(254, 2)) : phase_limit[p]);
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) begin
        make_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        bytes_sent += (line_q.size() > LineCapacity) ? LineCapacity : line_q.size();
      end
      drain();
    end

    $display("Covered %0d line ends and %0d result beats under five channel limits,",
             sb.lines_ended, sb.beats_checked);
    $display("including 0 and 255, with sender gaps and receiver stalls mixed in.");
    if (sb.errors == 0) begin
      $display("serial_command_line_parser_top: match");
    end else begin
      $display("serial_command_line_parser_top: mismatch");
    end
    $finish;
  end

endmodule
